FILE: sv/llcp_pkg.sv
// shared types and constants for the line-to-line closest point pipeline
`timescale 1ns / 1ps
package llcp_pkg;

    // digit width of the partial-product multipliers
    localparam int MUL_DIGIT = 16;

    // enable and valid of the stage before, for multiplier and divider
    typedef struct packed {
        logic en;
        logic vld;
    } pipe_ctl_t;

endpackage

FILE: sv/line_line_closest_point_unit.sv
// top level: closest point on line a to line b, fully pipelined
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid in_ready a0_* .. b1_*   | request in
//  out     | out_valid out_ready near_* flags | request out
//
// one request per cycle while the output is not stalled; the pipeline holds the
// divider (coord_width + frac_bits + 3 stages) and the two digit multipliers
// reset clears only the valid bits of every stage
// a stall at the output freezes the whole pipeline, nothing is dropped or repeated
`timescale 1ns / 1ps
module line_line_closest_point_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] a0_x,
    input  logic signed [COORD_WIDTH-1:0] a0_y,
    input  logic signed [COORD_WIDTH-1:0] a0_z,
    input  logic signed [COORD_WIDTH-1:0] a1_x,
    input  logic signed [COORD_WIDTH-1:0] a1_y,
    input  logic signed [COORD_WIDTH-1:0] a1_z,
    input  logic signed [COORD_WIDTH-1:0] b0_x,
    input  logic signed [COORD_WIDTH-1:0] b0_y,
    input  logic signed [COORD_WIDTH-1:0] b0_z,
    input  logic signed [COORD_WIDTH-1:0] b1_x,
    input  logic signed [COORD_WIDTH-1:0] b1_y,
    input  logic signed [COORD_WIDTH-1:0] b1_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] near_x,
    output logic signed [COORD_WIDTH-1:0] near_y,
    output logic signed [COORD_WIDTH-1:0] near_z,
    output logic                          degenerate,
    output logic                          clipped
);
    import llcp_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int DW1   = W + 1;
    localparam int PRW   = 2 * DW1;
    localparam int DOTW  = PRW + 2;
    localparam int MW2   = 2 * DOTW;
    localparam int NDW   = MW2 + 1;
    localparam int NMAG  = NDW + F;
    localparam int QB    = W + F + 2;
    localparam int MUAW  = W + F + 4;
    localparam int OPW   = MUAW + DW1;
    localparam int OFW   = OPW + 2;
    localparam int SMW   = OPW + 3;
    localparam int SW1   = 3 * W + 3 * DW1;
    localparam int SW2   = SW1 + 2;
    localparam int SW3   = 3 * W + 1;

    localparam logic [QB:0]      LIM  = {2'b01, {(QB-1){1'b0}}};
    localparam logic [OPW:0]     HALF = (F > 0) ? ((OPW+1)'(1) << (F - 1)) : '0;
    localparam logic [SMW-1:0]   HI   = {{(SMW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [SMW-1:0]   LO   = {{(SMW-W+1){1'b1}}, {(W-1){1'b0}}};

    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    logic signed [W-1:0] pa [3];
    logic signed [W-1:0] pb [3];
    logic signed [W-1:0] pc [3];
    logic signed [W-1:0] pd [3];
    assign pa = '{a0_x, a0_y, a0_z};
    assign pb = '{a1_x, a1_y, a1_z};
    assign pc = '{b0_x, b0_y, b0_z};
    assign pd = '{b1_x, b1_y, b1_z};

    // stage 1: differences
    logic                  v1_reg;
    logic signed [W-1:0]   p1_reg  [3];
    logic signed [DW1-1:0] p13_reg [3];
    logic signed [DW1-1:0] p43_reg [3];
    logic signed [DW1-1:0] p21_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p1_reg[k]  <= pa[k];
                p13_reg[k] <= pa[k] - pc[k];
                p43_reg[k] <= pd[k] - pc[k];
                p21_reg[k] <= pb[k] - pa[k];
            end
        end
    end

    // stage 2: per-axis products, order 1343 4321 1321 4343 2121
    logic                  v2_reg;
    logic signed [PRW-1:0] m_reg   [5][3];
    logic signed [W-1:0]   p1s2_reg  [3];
    logic signed [DW1-1:0] p21s2_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                m_reg[0][k]  <= p13_reg[k] * p43_reg[k];
                m_reg[1][k]  <= p43_reg[k] * p21_reg[k];
                m_reg[2][k]  <= p13_reg[k] * p21_reg[k];
                m_reg[3][k]  <= p43_reg[k] * p43_reg[k];
                m_reg[4][k]  <= p21_reg[k] * p21_reg[k];
                p1s2_reg[k]  <= p1_reg[k];
                p21s2_reg[k] <= p21_reg[k];
            end
        end
    end

    // stage 3: dot products
    logic                   v3_reg;
    logic signed [DOTW-1:0] dot_reg [5];
    logic signed [W-1:0]    p1s3_reg  [3];
    logic signed [DW1-1:0]  p21s3_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 5; j++)
            begin
                dot_reg[j] <= m_reg[j][0] + m_reg[j][1] + m_reg[j][2];
            end
            p1s3_reg  <= p1s2_reg;
            p21s3_reg <= p21s2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // products of dot products for denom and numer
    logic [3:0][DOTW-1:0] ma;
    logic [3:0][DOTW-1:0] mb;
    logic [3:0][MW2-1:0]  mp;
    logic [SW1-1:0]       side1;
    logic [SW1-1:0]       side1_out;
    logic                 vm1;
    pipe_ctl_t            ctl_m1;

    assign ma[0] = dot_reg[4];
    assign mb[0] = dot_reg[3];
    assign ma[1] = dot_reg[1];
    assign mb[1] = dot_reg[1];
    assign ma[2] = dot_reg[0];
    assign mb[2] = dot_reg[1];
    assign ma[3] = dot_reg[2];
    assign mb[3] = dot_reg[3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            side1[k*W +: W]             = p1s3_reg[k];
            side1[3*W + k*DW1 +: DW1]   = p21s3_reg[k];
        end
    end

    assign ctl_m1 = '{en: en, vld: v3_reg};

    llcp_mul #(
        .LANES (4),
        .WA    (DOTW),
        .WB    (DOTW),
        .SW    (SW1),
        .DIG   (MUL_DIGIT)
    ) u_mul_nd (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_m1),
        .a        (ma),
        .b        (mb),
        .side_in  (side1),
        .out_vld  (vm1),
        .p        (mp),
        .side_out (side1_out)
    );

    // stage 4: denom, numer magnitude, degenerate test
    logic signed [NDW-1:0] den_c;
    logic signed [NDW-1:0] num_c;
    logic [NDW-1:0]        num_abs;

    assign den_c   = $signed(mp[0]) - $signed(mp[1]);
    assign num_c   = $signed(mp[2]) - $signed(mp[3]);
    assign num_abs = num_c[NDW-1] ? NDW'(-num_c) : NDW'(num_c);

    logic            v4_reg;
    logic [NMAG-1:0] n_reg;
    logic [NDW-1:0]  d_reg;
    logic [SW2-1:0]  side2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg     <= NMAG'(num_abs) << F;
            d_reg     <= NDW'(den_c);
            side2_reg <= {den_c[NDW-1] || (den_c == '0), num_c[NDW-1], side1_out};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= vm1;
        end
    end

    // mua = round(numer * 2^f / denom)
    pipe_ctl_t      ctl_dv;
    logic           vdv;
    logic [QB-1:0]  dq;
    logic [NDW-1:0] drem;
    logic           dovf;
    logic [NDW-1:0] dden;
    logic [SW2-1:0] side2_out;

    assign ctl_dv = '{en: en, vld: v4_reg};

    llcp_div #(
        .NW (NMAG),
        .DW (NDW),
        .QB (QB),
        .SW (SW2)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_dv),
        .n        (n_reg),
        .d        (d_reg),
        .side_in  (side2_reg),
        .out_vld  (vdv),
        .q        (dq),
        .rem      (drem),
        .ovf      (dovf),
        .d_out    (dden),
        .side_out (side2_out)
    );

    // stage 5: rounding of the quotient, clamp, sign
    logic [QB:0]            qr;
    logic [QB:0]            qmag;
    logic                   neg_s5;

    assign qr     = (QB+1)'(dq) + (QB+1)'({drem, 1'b0} >= {1'b0, dden});
    assign qmag   = (dovf || (qr > LIM)) ? LIM : qr;
    assign neg_s5 = side2_out[SW1];

    logic                   v5_reg;
    logic signed [MUAW-1:0] mua_reg;
    logic [SW3-1:0]         side3_reg;
    logic [3*DW1-1:0]       p21s5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mua_reg   <= neg_s5 ? -$signed(MUAW'(qmag)) : $signed(MUAW'(qmag));
            side3_reg <= {side2_out[SW1+1], side2_out[3*W-1:0]};
            p21s5_reg <= side2_out[SW1-1:3*W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= vdv;
        end
    end

    // mua times each axis of p21
    pipe_ctl_t            ctl_m2;
    logic [2:0][MUAW-1:0] ua;
    logic [2:0][DW1-1:0]  ub;
    logic [2:0][OPW-1:0]  up;
    logic [SW3-1:0]       side3_out;
    logic                 vm2;

    assign ctl_m2 = '{en: en, vld: v5_reg};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ua[k] = mua_reg;
            ub[k] = p21s5_reg[k*DW1 +: DW1];
        end
    end

    llcp_mul #(
        .LANES (3),
        .WA    (MUAW),
        .WB    (DW1),
        .SW    (SW3),
        .DIG   (MUL_DIGIT)
    ) u_mul_off (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_m2),
        .a        (ua),
        .b        (ub),
        .side_in  (side3_reg),
        .out_vld  (vm2),
        .p        (up),
        .side_out (side3_out)
    );

    // stage 6: offset rounded to nearest, ties away from zero
    logic [OPW-1:0]        omag [3];
    logic [OPW:0]          ornd [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            omag[k] = up[k][OPW-1] ? OPW'(-$signed(up[k])) : up[k];
            ornd[k] = ((OPW+1)'(omag[k]) + HALF) >> F;
        end
    end

    logic                  v6_reg;
    logic signed [OFW-1:0] off_reg [3];
    logic [SW3-1:0]        side4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                off_reg[k] <= up[k][OPW-1] ? -$signed(OFW'(ornd[k])) : $signed(OFW'(ornd[k]));
            end
            side4_reg <= side3_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v6_reg <= vm2;
        end
    end

    // output stage: add to p1 and saturate, or pass p1 through for a degenerate pair
    logic signed [W-1:0]   p1o  [3];
    logic signed [SMW-1:0] sum  [3];
    logic signed [W-1:0]   res  [3];
    logic [2:0]            sat;
    logic                  dg_o;

    assign dg_o = side4_reg[SW3-1];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            p1o[k] = $signed(side4_reg[k*W +: W]);
            sum[k] = p1o[k] + off_reg[k];
            sat[k] = 1'b0;
            res[k] = W'(sum[k]);
            if (dg_o)
            begin
                res[k] = p1o[k];
            end
            else if (sum[k] > $signed(HI))
            begin
                res[k] = W'(HI);
                sat[k] = 1'b1;
            end
            else if (sum[k] < $signed(LO))
            begin
                res[k] = W'(LO);
                sat[k] = 1'b1;
            end
        end
    end

    logic signed [W-1:0] near_reg [3];
    logic                deg_reg;
    logic                clip_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            near_reg <= res;
            deg_reg  <= dg_o;
            clip_reg <= |sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v6_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign near_x     = near_reg[0];
    assign near_y     = near_reg[1];
    assign near_z     = near_reg[2];
    assign degenerate = deg_reg;
    assign clipped    = clip_reg;

endmodule

FILE: sv/llcp_mul.sv
// multi-lane signed multiplier, one digit of b per pipeline stage
`timescale 1ns / 1ps
module llcp_mul #(
    parameter int LANES = 1,
    parameter int WA = 16,
    parameter int WB = 16,
    parameter int SW = 1,
    parameter int DIG = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  llcp_pkg::pipe_ctl_t                ctl,
    input  logic [LANES-1:0][WA-1:0]           a,
    input  logic [LANES-1:0][WB-1:0]           b,
    input  logic [SW-1:0]                      side_in,
    output logic                               out_vld,
    output logic [LANES-1:0][WA+WB-1:0]        p,
    output logic [SW-1:0]                      side_out
);
    import llcp_pkg::*;

    localparam int NS = (WB + DIG - 1) / DIG;
    localparam int PW = WA + WB;
    localparam int LW = WB - (NS - 1) * DIG;

    logic [LANES-1:0][PW-1:0] acc_reg [NS];
    logic [LANES-1:0][WA-1:0] a_reg [NS-1];
    logic [LANES-1:0][WB-1:0] b_reg [NS-1];
    logic [SW-1:0]            side_reg [NS];
    logic [NS-1:0]            vld_reg;

    for (genvar s = 0; s < NS; s++) begin : g_st
        logic [LANES-1:0][WA-1:0] a_s;
        logic [LANES-1:0][WB-1:0] b_s;
        logic [LANES-1:0][PW-1:0] acc_s;
        logic [LANES-1:0][PW-1:0] acc_next;
        logic [SW-1:0]            side_s;
        logic                     vld_s;

        if (s == 0) begin : g_first
            assign a_s    = a;
            assign b_s    = b;
            assign acc_s  = '0;
            assign side_s = side_in;
            assign vld_s  = ctl.vld;
        end else begin : g_rest
            assign a_s    = a_reg[s-1];
            assign b_s    = b_reg[s-1];
            assign acc_s  = acc_reg[s-1];
            assign side_s = side_reg[s-1];
            assign vld_s  = vld_reg[s-1];
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic signed [PW-1:0] pp;
            if (s == NS - 1) begin : g_top
                // top digit carries the sign of b
                assign pp = $signed(a_s[l]) * $signed(b_s[l][WB-1 -: LW]);
            end else begin : g_low
                assign pp = $signed(a_s[l]) * $signed({1'b0, b_s[l][s*DIG +: DIG]});
            end
            assign acc_next[l] = acc_s[l] + PW'(pp <<< (s * DIG));
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (ctl.en)
            begin
                vld_reg[s] <= vld_s;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                acc_reg[s]  <= acc_next;
                side_reg[s] <= side_s;
            end
        end

        if (s < NS - 1) begin : g_pass
            always_ff @(posedge clk)
            begin
                if (ctl.en)
                begin
                    a_reg[s] <= a_s;
                    b_reg[s] <= b_s;
                end
            end
        end
    end

    assign out_vld  = vld_reg[NS-1];
    assign p        = acc_reg[NS-1];
    assign side_out = side_reg[NS-1];

endmodule

FILE: sv/llcp_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
`timescale 1ns / 1ps
module llcp_div #(
    parameter int NW = 16,
    parameter int DW = 16,
    parameter int QB = 8,
    parameter int SW = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  llcp_pkg::pipe_ctl_t ctl,
    input  logic [NW-1:0]       n,
    input  logic [DW-1:0]       d,
    input  logic [SW-1:0]       side_in,
    output logic                out_vld,
    output logic [QB-1:0]       q,
    output logic [DW-1:0]       rem,
    output logic                ovf,
    output logic [DW-1:0]       d_out,
    output logic [SW-1:0]       side_out
);
    import llcp_pkg::*;

    localparam int RW = DW + QB;

    logic [RW-1:0] rem_reg  [QB+1];
    logic [QB-1:0] q_reg    [QB+1];
    logic [DW-1:0] d_reg    [QB+1];
    logic [SW-1:0] side_reg [QB+1];
    logic [QB:0]   ovf_reg;
    logic [QB:0]   vld_reg;

    // first stage: quotient too large for the bits kept
    logic [RW-1:0] n_ext;
    assign n_ext = RW'(n);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (ctl.en)
        begin
            vld_reg[0] <= ctl.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            rem_reg[0]  <= n_ext;
            q_reg[0]    <= '0;
            d_reg[0]    <= d;
            side_reg[0] <= side_in;
            ovf_reg[0]  <= n_ext >= (RW'(d) << QB);
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_bit
        logic [RW-1:0] ds;
        logic          take;
        logic [RW-1:0] rem_next;
        logic [QB-1:0] q_next;

        assign ds   = RW'(d_reg[j-1]) << (QB - j);
        assign take = !ovf_reg[j-1] && (rem_reg[j-1] >= ds);

        always_comb
        begin
            rem_next = rem_reg[j-1];
            q_next   = q_reg[j-1];
            if (take)
            begin
                rem_next        = rem_reg[j-1] - ds;
                q_next[QB - j]  = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (ctl.en)
            begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                rem_reg[j]  <= rem_next;
                q_reg[j]    <= q_next;
                d_reg[j]    <= d_reg[j-1];
                side_reg[j] <= side_reg[j-1];
                ovf_reg[j]  <= ovf_reg[j-1];
            end
        end
    end

    assign out_vld  = vld_reg[QB];
    assign q        = q_reg[QB];
    assign rem      = rem_reg[QB][DW-1:0];
    assign ovf      = ovf_reg[QB];
    assign d_out    = d_reg[QB];
    assign side_out = side_reg[QB];

endmodule

FILE: sv/llcp_chk.sv
// port-level checks for the closest point unit, bound to the top level
`timescale 1ns / 1ps
module llcp_chk #(
    parameter int W = 32
) (
    input logic         clk,
    input logic         rst_n,
    input logic         in_ready,
    input logic         out_valid,
    input logic         out_ready,
    input logic [W-1:0] near_x,
    input logic [W-1:0] near_y,
    input logic [W-1:0] near_z,
    input logic         degenerate,
    input logic         clipped
);

    // a waiting result request is held
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(near_x) && $stable(near_y)
            && $stable(near_z) && $stable(degenerate) && $stable(clipped))
        else $error("result payload changed while stalled");

    // the pipeline can always take a request when nothing waits at the output
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // a degenerate result is the first point and never saturates
    a_deg_clip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> !clipped)
        else $error("degenerate result flagged as clipped");

endmodule

bind line_line_closest_point_unit llcp_chk #(.W(COORD_WIDTH)) u_chk (.*);
